// ----- rtl/core/ptl_pkg.sv -----
// ptl_pkg: shared types and constants of the pattern token lexer
// token kinds, error codes, byte codes and the result record
// no dependencies
package ptl_pkg;

  // token kinds
  localparam logic [3:0] K_IDENT    = 4'd0;
  localparam logic [3:0] K_ANY      = 4'd1;
  localparam logic [3:0] K_INT      = 4'd2;
  localparam logic [3:0] K_REAL     = 4'd3;
  localparam logic [3:0] K_STRING   = 4'd4;
  localparam logic [3:0] K_CHAR     = 4'd5;
  localparam logic [3:0] K_LPAREN   = 4'd6;
  localparam logic [3:0] K_RPAREN   = 4'd7;
  localparam logic [3:0] K_LBRACKET = 4'd8;
  localparam logic [3:0] K_RBRACKET = 4'd9;
  localparam logic [3:0] K_COMMA    = 4'd10;
  localparam logic [3:0] K_END      = 4'd11;
  localparam logic [3:0] K_ERROR    = 4'd12;

  // error codes
  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_BAD_CHAR   = 3'd1;
  localparam logic [2:0] E_OPEN_QUOTE = 3'd2;
  localparam logic [2:0] E_UNEXPECTED = 3'd3;
  localparam logic [2:0] E_OVERFLOW   = 3'd4;
  localparam logic [2:0] E_TOO_LONG   = 3'd5;

  // byte codes
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_DOT    = 8'h2E;
  localparam logic [7:0] C_STAR   = 8'h2A;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_COMMA  = 8'h2C;
  localparam logic [7:0] C_LBRACK = 8'h5B;
  localparam logic [7:0] C_RBRACK = 8'h5D;
  localparam logic [7:0] C_SQUOTE = 8'h27;
  localparam logic [7:0] C_DQUOTE = 8'h22;
  localparam logic [7:0] C_ZERO   = 8'h30;
  localparam logic [7:0] C_NINE   = 8'h39;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_CR     = 8'h0D;

  // floor((2^63 - 1) / 10), the largest accumulator that may take another digit
  localparam logic [63:0] ACC_LIMIT = 64'h0CCC_CCCC_CCCC_CCCC;

  localparam int DATA_W = 112;
  localparam int USER_W = 4;

  // one result, integer value kept as magnitude and sign
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [63:0] mag;
    logic        neg;
    logic [7:0]  cval;
    logic [2:0]  err;
  } res_t;

  // results caused by one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]       count;
    res_t [2:0]       slot;
  } group_t;

endpackage

// ----- rtl/core/pattern_token_lexer.sv -----
// pattern_token_lexer: streaming lexer for pattern text, top level
// input register, ptl_core (lexer step) and ptl_emit (result buffer)
// depends on ptl_pkg, ptl_core, ptl_emit
//
// channel  dir  tdata                                   tuser         tlast
// s_*      in   [7:0] character                         -             final byte
// m_*      out  [15:0] start_pos, [31:16] token_length, [3:0] kind    last result
//               [95:32] int_value, [103:96] char_value,               of this byte
//               [106:104] error_code, [111:107] zero
//
// one byte per cycle while every byte yields at most one result and m_tready
// is high; a byte with more results holds the input side while the result
// buffer still has more than one of them to deliver through its single output
// port. a result passes the input register, then the result buffer, before it
// is presented on m_*.
// rst is synchronous and clears the lexer state and both valid flags; no
// clearing pass. a stall on m_tready holds the buffer, then the input register,
// then drops s_tready.
module pattern_token_lexer
  import ptl_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] character
  input  logic              s_tlast,   // final byte of the pattern
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // start_pos, token_length, int_value,
                                       // char_value, error_code, zero fill
  output logic [USER_W-1:0] m_tuser,   // [3:0] token_kind
  output logic              m_tlast    // last result caused by this byte
);

  // input register
  logic       in_v;
  logic [7:0] in_char;
  logic       in_fin;

  // handshake between stages
  logic   fire;
  logic   load_ok;
  group_t grp;

  // the held byte is processed once the result buffer can take its results
  assign fire     = in_v && load_ok;
  assign s_tready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_fin  <= s_tlast;
    end
  end

  // lexer step: state registers advance on fire
  ptl_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ch   (in_char),
    .fin  (in_fin),
    .grp  (grp)
  );

  // result buffer, one result per output transaction
  ptl_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .grp      (grp),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- rtl/core/ptl_core.sv -----
// ptl_core: lexer state registers and the per-byte next-state and result logic
// produces up to three results for each byte taken
// depends on ptl_pkg
module ptl_core
  import ptl_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] ch,
  input  logic       fin,
  output group_t     grp
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_IDENT  = 9'b000000010,
    ST_MINUS  = 9'b000000100,
    ST_INT    = 9'b000001000,
    ST_REAL   = 9'b000010000,
    ST_CHAR1  = 9'b000100000,
    ST_CHAR2  = 9'b001000000,
    ST_STRING = 9'b010000000,
    ST_SKIP   = 9'b100000000
  } lex_state_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  lex_state_t               st, st_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] ts, ts_next;
  logic [63:0]              acc, acc_next;
  logic                     neg, neg_next;
  logic                     ovf, ovf_next;
  logic [7:0]               hc, hc_next;

  logic [3:0]  digit;
  logic        lim_up;
  logic [63:0] acc_mac;
  logic        acc_over;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= C_ZERO) && (c <= C_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == C_SPACE) || ((c >= C_TAB) && (c <= C_CR));
  endfunction

  function automatic logic in_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == C_SQUOTE) || (c == C_DOT);
  endfunction

  function automatic logic [15:0] to16(input logic [POSITION_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return w[15:0];
  endfunction

  function automatic logic [15:0] len_plus1(input logic [POSITION_BITS-1:0] d);
    logic [POSITION_BITS:0] e;
    logic [32:0]            w;
    e = {1'b0, d} + {{POSITION_BITS{1'b0}}, 1'b1};
    w = 33'(e);
    return w[15:0];
  endfunction

  function automatic res_t mk(input logic [3:0] kind, input logic [15:0] start,
                              input logic [15:0] len, input logic [63:0] mag,
                              input logic n, input logic [7:0] cval,
                              input logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.mag   = mag;
    r.neg   = n;
    r.cval  = cval;
    r.err   = err;
    return r;
  endfunction

  // pending identifier or number ending before offset p
  function automatic res_t flush_res(input lex_state_t s, input logic [POSITION_BITS-1:0] t,
                                     input logic [POSITION_BITS-1:0] p,
                                     input logic [63:0] a, input logic n, input logic o);
    logic [15:0] l;
    res_t        r;
    l = to16(p - t);
    if (s == ST_IDENT) begin
      r = mk(K_IDENT, to16(t), l, 64'd0, 1'b0, 8'd0, E_NONE);
    end else if (s == ST_REAL) begin
      r = mk(K_REAL, to16(t), l, 64'd0, 1'b0, 8'd0, E_NONE);
    end else if (o) begin
      r = mk(K_ERROR, to16(t), l, 64'd0, 1'b0, 8'd0, E_OVERFLOW);
    end else begin
      r = mk(K_INT, to16(t), l, a, n, 8'd0, E_NONE);
    end
    return r;
  endfunction

  // one decimal digit onto the registered accumulator
  assign digit    = 4'(ch - C_ZERO);
  assign lim_up   = neg ? (digit > 4'd8) : (digit > 4'd7);
  assign acc_mac  = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, digit};
  assign acc_over = acc > (ACC_LIMIT - {63'd0, lim_up});

  always_comb begin
    logic [1:0]               n;
    logic                     fl;
    logic                     bg;
    logic [POSITION_BITS-1:0] diff;
    res_t [2:0]               slot;
    st_next  = st;
    pos_next = pos;
    ts_next  = ts;
    acc_next = acc;
    neg_next = neg;
    ovf_next = ovf;
    hc_next  = hc;
    n        = 2'd0;
    fl       = 1'b0;
    bg       = 1'b0;
    slot     = '0;
    diff     = pos - ts;

    if (st == ST_SKIP) begin
      // dropping bytes up to the end of the pattern
    end else if (pos == POS_MAX) begin
      ts_next = pos;
      slot[n] = mk(K_ERROR, to16(pos), 16'd0, 64'd0, 1'b0, 8'd0, E_TOO_LONG);
      n       = n + 2'd1;
      st_next = ST_SKIP;
    end else begin
      unique case (st)
        ST_IDENT: begin
          if (!in_ident(ch)) begin
            fl = 1'b1;
            bg = 1'b1;
          end
        end
        ST_MINUS: begin
          if (is_digit(ch)) begin
            acc_next = {60'd0, digit};
            neg_next = 1'b1;
            ovf_next = 1'b0;
            st_next  = ST_INT;
          end else begin
            slot[n] = mk(K_ERROR, to16(ts), len_plus1(diff), 64'd0, 1'b0, 8'd0,
                         E_UNEXPECTED);
            n       = n + 2'd1;
            st_next = ST_SKIP;
          end
        end
        ST_INT: begin
          if (is_digit(ch)) begin
            if (!ovf) begin
              if (acc_over) begin
                ovf_next = 1'b1;
              end else begin
                acc_next = acc_mac;
              end
            end
          end else if (ch == C_DOT) begin
            st_next = ST_REAL;
          end else begin
            fl = 1'b1;
            bg = 1'b1;
          end
        end
        ST_REAL: begin
          if (!is_digit(ch)) begin
            fl = 1'b1;
            bg = 1'b1;
          end
        end
        ST_CHAR1: begin
          hc_next = ch;
          st_next = ST_CHAR2;
        end
        ST_CHAR2: begin
          if (ch == C_SQUOTE) begin
            slot[n] = mk(K_CHAR, to16(ts), 16'd3, 64'd0, 1'b0, hc, E_NONE);
            n       = n + 2'd1;
            st_next = ST_IDLE;
          end else begin
            slot[n] = mk(K_ERROR, to16(ts), 16'd3, 64'd0, 1'b0, 8'd0, E_BAD_CHAR);
            n       = n + 2'd1;
            st_next = ST_SKIP;
          end
        end
        ST_STRING: begin
          if (ch == C_DQUOTE) begin
            slot[n] = mk(K_STRING, to16(ts), len_plus1(diff), 64'd0, 1'b0, 8'd0, E_NONE);
            n       = n + 2'd1;
            st_next = ST_IDLE;
          end
        end
        ST_IDLE: bg = 1'b1;
        default: bg = 1'b1;
      endcase

      if (fl) begin
        slot[n] = flush_res(st, ts, pos, acc, neg, ovf);
        n       = n + 2'd1;
        st_next = (st == ST_INT && ovf) ? ST_SKIP : ST_IDLE;
      end

      if (bg && st_next != ST_SKIP) begin
        ts_next = pos;
        st_next = ST_IDLE;
        priority if (is_space(ch)) begin
          // whitespace starts nothing
        end else if (ch == C_LPAREN) begin
          slot[n] = mk(K_LPAREN, to16(pos), 16'd1, 64'd0, 1'b0, 8'd0, E_NONE);
          n       = n + 2'd1;
        end else if (ch == C_RPAREN) begin
          slot[n] = mk(K_RPAREN, to16(pos), 16'd1, 64'd0, 1'b0, 8'd0, E_NONE);
          n       = n + 2'd1;
        end else if (ch == C_LBRACK) begin
          slot[n] = mk(K_LBRACKET, to16(pos), 16'd1, 64'd0, 1'b0, 8'd0, E_NONE);
          n       = n + 2'd1;
        end else if (ch == C_RBRACK) begin
          slot[n] = mk(K_RBRACKET, to16(pos), 16'd1, 64'd0, 1'b0, 8'd0, E_NONE);
          n       = n + 2'd1;
        end else if (ch == C_COMMA) begin
          slot[n] = mk(K_COMMA, to16(pos), 16'd1, 64'd0, 1'b0, 8'd0, E_NONE);
          n       = n + 2'd1;
        end else if (ch == C_STAR) begin
          slot[n] = mk(K_ANY, to16(pos), 16'd1, 64'd0, 1'b0, 8'd0, E_NONE);
          n       = n + 2'd1;
        end else if (ch == C_SQUOTE) begin
          st_next = ST_CHAR1;
        end else if (ch == C_DQUOTE) begin
          st_next = ST_STRING;
        end else if (is_digit(ch)) begin
          acc_next = {60'd0, digit};
          neg_next = 1'b0;
          ovf_next = 1'b0;
          st_next  = ST_INT;
        end else if (ch == C_MINUS) begin
          st_next = ST_MINUS;
        end else if (is_alpha(ch)) begin
          st_next = ST_IDENT;
        end else begin
          slot[n] = mk(K_ERROR, to16(pos), 16'd1, 64'd0, 1'b0, 8'd0, E_UNEXPECTED);
          n       = n + 2'd1;
          st_next = ST_SKIP;
        end
      end

      pos_next = pos + POS_ONE;
    end

    // end of pattern: close what is open, then the end token if no error stopped the pattern
    if (fin) begin
      diff = pos_next - ts_next;
      if (st_next == ST_IDENT || st_next == ST_INT || st_next == ST_REAL) begin
        slot[n] = flush_res(st_next, ts_next, pos_next, acc_next, neg_next, ovf_next);
        n       = n + 2'd1;
        if (st_next == ST_INT && ovf_next) begin
          st_next = ST_SKIP;
        end
      end else if (st_next == ST_MINUS) begin
        slot[n] = mk(K_ERROR, to16(ts_next), to16(diff), 64'd0, 1'b0, 8'd0, E_UNEXPECTED);
        n       = n + 2'd1;
        st_next = ST_SKIP;
      end else if (st_next == ST_CHAR1 || st_next == ST_CHAR2) begin
        slot[n] = mk(K_ERROR, to16(ts_next), to16(diff), 64'd0, 1'b0, 8'd0, E_BAD_CHAR);
        n       = n + 2'd1;
        st_next = ST_SKIP;
      end else if (st_next == ST_STRING) begin
        slot[n] = mk(K_ERROR, to16(ts_next), to16(diff), 64'd0, 1'b0, 8'd0, E_OPEN_QUOTE);
        n       = n + 2'd1;
        st_next = ST_SKIP;
      end
      if (st_next != ST_SKIP) begin
        slot[n] = mk(K_END, to16(pos_next), 16'd0, 64'd0, 1'b0, 8'd0, E_NONE);
        n       = n + 2'd1;
      end
      st_next  = ST_IDLE;
      pos_next = '0;
    end

    grp.count = n;
    grp.slot  = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_IDLE;
      pos <= '0;
      ts  <= '0;
      acc <= '0;
      neg <= 1'b0;
      ovf <= 1'b0;
      hc  <= '0;
    end else if (fire) begin
      st  <= st_next;
      pos <= pos_next;
      ts  <= ts_next;
      acc <= acc_next;
      neg <= neg_next;
      ovf <= ovf_next;
      hc  <= hc_next;
    end
  end

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && st == ST_SKIP) |-> grp.count == 2'd0)
    else $error("byte dropped after an error produced a result");

  a_fin_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && fin) |=> (st == ST_IDLE && pos == '0))
    else $error("pattern end did not restart the lexer");

  a_fin_reports: assert property (@(posedge clk) disable iff (rst)
    (fire && fin && st != ST_SKIP) |-> grp.count != 2'd0)
    else $error("pattern end gave neither an end token nor an error");

endmodule

// ----- rtl/core/ptl_emit.sv -----
// ptl_emit: result buffer holding the results of one byte, delivered one per transaction
// applies the sign to integer values and packs the output stream
// depends on ptl_pkg
module ptl_emit
  import ptl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  group_t            grp,
  output logic              load_ok,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  res_t [2:0]  slot;
  logic [1:0]  cnt;
  logic        pop;
  logic [63:0] ival;

  assign pop     = (cnt != 2'd0) && m_tready;
  assign load_ok = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= grp.slot;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign ival     = slot[0].neg ? (64'd0 - slot[0].mag) : slot[0].mag;
  assign m_tvalid = cnt != 2'd0;
  assign m_tlast  = cnt == 2'd1;
  assign m_tuser  = slot[0].kind;
  assign m_tdata  = {5'd0, slot[0].err, slot[0].cval, ival, slot[0].len, slot[0].start};

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == 2'd0 || (cnt == 2'd1 && m_tready)))
    else $error("results loaded over undelivered results");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && cnt != 2'd1) |=> cnt == $past(cnt) - 2'd1)
    else $error("result count did not step down on delivery");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && grp.count != 2'd0) |=> m_tvalid)
    else $error("loaded results not presented");

endmodule
